// File: rtl/cra_pkg.sv
// Shared types and constants for the checked rational ALU.
// No dependencies; imported by every other file of the block but rtl/cra_mul.sv.
package cra_pkg;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [63:0] a_num;
    logic signed [63:0] a_den;
    logic signed [63:0] b_num;
    logic [62:0]        b_den;
    logic signed [63:0] exponent;
  } in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic [1:0]         status;
  } out_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [2:0] FN_NORM = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;
  localparam logic [2:0] FN_POW  = 3'd5;

  localparam logic [63:0] S64_MIN = {1'b1, 63'd0};

  typedef enum logic [1:0] {SEL_XN, SEL_XD, SEL_YN, SEL_YD} opsel_e;

  typedef struct packed {
    logic       load;
    logic       x_to_t;
    logic       swap_t;
    logic       addsub;
    logic       sub;
    logic       neg_tn;
    logic       mul_start;
    opsel_e     mul_a;
    opsel_e     mul_b;
    logic       mul_abs_b;
    logic       mul_dst;     // 0: tn, 1: td
    logic       norm_start;
    logic       norm_dst;    // 0: x, 1: y
    logic       acc_one;
    logic       copy_xy;
    logic       k_neg;
    logic       k_shift;
    logic       finish;
    logic [1:0] fin_status;
  } cmd_t;

  typedef struct packed {
    logic       mul_done;
    logic       mul_ovf;
    logic       norm_done;
    logic [1:0] norm_st;
    logic       as_ovf;
    logic       yn_zero;
    logic       yn_min;
    logic       yn_neg;
    logic       xn_zero;
    logic       k_zero;
    logic       k_sign;
    logic       k_min;
    logic       k_lsb;
    logic       k_last;
    logic       tn_min;
    logic       out_free;
  } sts_t;

endpackage

// File: rtl/checked_rational_alu.sv
// Checked rational ALU, one transaction in flight at a time.
// Each normalisation does sign checks, binary gcd steps and an exact division;
// power runs up to four multiplies and two normalisations per exponent bit
// (at most 63 bits). A new transaction is accepted only after the last one
// has reached the output register, where a result may wait. Reset clears all
// control and the output valid.
module checked_rational_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cra_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cra_pkg::out_t out_data_o
);
  import cra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_func_i  (in_data_i.func),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cra_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/cra_mul.sv
// Checked signed 64x64 multiplier: four 32x32 partial products over
// successive cycles into a 128-bit accumulator. No package dependencies.
module cra_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  input  logic               abs_b_i,
  output logic               done_o,
  output logic               ovf_o,
  output logic signed [63:0] prod_o
);

  logic [63:0]  ua_q, ub_q, pp_q;
  logic [127:0] acc_q, term;
  logic [1:0]   sh_q, sh;
  logic [2:0]   cnt_q;
  logic         neg_q, busy_q, done_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp, lim;

  assign pa = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
  assign pb = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
  assign pp = {32'd0, pa} * {32'd0, pb};
  assign sh = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};

  always_comb begin
    case (sh_q)
      2'd0:    term = {64'd0, pp_q};
      2'd1:    term = {32'd0, pp_q, 32'd0};
      default: term = {pp_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= a_i[63] ? 64'd0 - a_i : a_i;
      ub_q  <= (b_i[63] && !abs_b_i) || (b_i[63] && abs_b_i) ? 64'd0 - b_i : b_i;
      neg_q <= a_i[63] != (b_i[63] && !abs_b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (!cnt_q[2]) begin
        pp_q <= pp;
        sh_q <= sh;
      end
      if (cnt_q != 3'd0) acc_q <= acc_q + term;
    end
  end

  assign lim    = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  assign ovf_o  = acc_q > {64'd0, lim};
  assign prod_o = neg_q ? 64'd0 - acc_q[63:0] : acc_q[63:0];
  assign done_o = done_q;

endmodule

// File: rtl/cra_norm.sv
// Rational normaliser: sign fix-up and checks, binary gcd one step a cycle,
// then exact restoring division of numerator and denominator. Uses cra_pkg.
module cra_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic [1:0]         st_o,
  output logic signed [63:0] rnum_o,
  output logic signed [63:0] rden_o
);
  import cra_pkg::*;

  localparam logic [1:0] N_IDLE = 2'd0;
  localparam logic [1:0] N_GCD  = 2'd1;
  localparam logic [1:0] N_DIVN = 2'd2;
  localparam logic [1:0] N_DIVD = 2'd3;

  logic [1:0]  state_q;
  logic        done_q;
  logic [1:0]  st_q;
  logic [5:0]  cnt_q, sh_q;
  logic [63:0] u_q, v_q, g_q, q_q, r_q, qn_q, dm_q, nm_q;
  logic        neg_q;
  logic [63:0] num_f, den_f, r_sh, q_nx;
  logic        ge, chk_dz, chk_ovf;

  assign num_f   = den_i[63] ? 64'd0 - num_i : num_i;
  assign den_f   = den_i[63] ? 64'd0 - den_i : den_i;
  assign chk_dz  = den_i == 64'sd0;
  assign chk_ovf = (num_i == S64_MIN) || (den_i == S64_MIN);

  assign r_sh = {r_q[62:0], q_q[63]};
  assign ge   = r_sh >= g_q;
  assign q_nx = {q_q[62:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      st_q    <= ST_OK;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            if (chk_dz) begin
              st_q   <= ST_DZ;
              done_q <= 1'b1;
            end else if (chk_ovf) begin
              st_q   <= ST_OVF;
              done_q <= 1'b1;
            end else begin
              st_q    <= ST_OK;
              state_q <= N_GCD;
            end
          end
        end
        N_GCD: begin
          if (u_q == 64'd0) begin
            state_q <= N_DIVN;
            cnt_q   <= '0;
          end
        end
        N_DIVN: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) state_q <= N_DIVD;
        end
        N_DIVD: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= N_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        neg_q <= num_f[63];
        nm_q  <= num_f[63] ? 64'd0 - num_f : num_f;
        dm_q  <= den_f;
        u_q   <= num_f[63] ? 64'd0 - num_f : num_f;
        v_q   <= den_f;
        sh_q  <= '0;
      end
      N_GCD: begin
        if (u_q == 64'd0) begin
          g_q <= v_q << sh_q;
          q_q <= nm_q;
          r_q <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q  <= u_q >> 1;
          v_q  <= v_q >> 1;
          sh_q <= sh_q + 6'd1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      default: begin
        // exact division by the gcd; second pass works on the denominator
        if (state_q == N_DIVN && cnt_q == 6'd63) begin
          qn_q <= q_nx;
          q_q  <= dm_q;
          r_q  <= '0;
        end else begin
          q_q <= q_nx;
          r_q <= ge ? r_sh - g_q : r_sh;
        end
      end
    endcase
  end

  assign done_o = done_q;
  assign st_o   = st_q;
  assign rnum_o = neg_q ? 64'd0 - qn_q : qn_q;
  assign rden_o = q_q;

endmodule

// File: rtl/cra_dp.sv
// Datapath: operand, product and exponent registers, checked add/subtract,
// output register; holds the multiplier and normaliser. Uses cra_pkg.
module cra_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cra_pkg::in_t  in_data_i,
  input  cra_pkg::cmd_t cmd_i,
  output cra_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cra_pkg::out_t out_data_o
);
  import cra_pkg::*;

  logic signed [63:0] xn_q, xd_q, yn_q, yd_q, tn_q, td_q;
  logic [63:0]        k_q;
  logic               mul_dst_q, norm_dst_q, out_valid_q;
  out_t               out_q;
  logic signed [63:0] mul_a, mul_b, prod, rnum, rden, as_r;
  logic               mul_done, mul_ovf, norm_done;
  logic [1:0]         norm_st;

  always_comb begin
    case (cmd_i.mul_a)
      SEL_XN:  mul_a = xn_q;
      SEL_XD:  mul_a = xd_q;
      SEL_YN:  mul_a = yn_q;
      default: mul_a = yd_q;
    endcase
    case (cmd_i.mul_b)
      SEL_XN:  mul_b = xn_q;
      SEL_XD:  mul_b = xd_q;
      SEL_YN:  mul_b = yn_q;
      default: mul_b = yd_q;
    endcase
  end

  cra_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .abs_b_i (cmd_i.mul_abs_b),
    .done_o  (mul_done),
    .ovf_o   (mul_ovf),
    .prod_o  (prod)
  );

  cra_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.norm_start),
    .num_i   (tn_q),
    .den_i   (td_q),
    .done_o  (norm_done),
    .st_o    (norm_st),
    .rnum_o  (rnum),
    .rden_o  (rden)
  );

  assign as_r = cmd_i.sub ? tn_q - td_q : tn_q + td_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xn_q <= in_data_i.a_num;
      xd_q <= in_data_i.a_den;
      yn_q <= in_data_i.b_num;
      yd_q <= {1'b0, in_data_i.b_den};
      k_q  <= in_data_i.exponent;
    end
    if (cmd_i.x_to_t) begin
      tn_q <= xn_q;
      td_q <= xd_q;
    end
    if (cmd_i.swap_t) begin
      tn_q <= xd_q;
      td_q <= xn_q;
    end
    if (cmd_i.addsub) tn_q <= as_r;
    if (cmd_i.neg_tn) tn_q <= 64'sd0 - tn_q;
    if (cmd_i.mul_start) mul_dst_q <= cmd_i.mul_dst;
    if (mul_done) begin
      if (mul_dst_q) td_q <= prod;
      else           tn_q <= prod;
    end
    if (cmd_i.norm_start) norm_dst_q <= cmd_i.norm_dst;
    if (norm_done) begin
      if (norm_dst_q) begin
        yn_q <= rnum;
        yd_q <= rden;
      end else begin
        xn_q <= rnum;
        xd_q <= rden;
      end
    end
    if (cmd_i.copy_xy) begin
      yn_q <= xn_q;
      yd_q <= xd_q;
    end
    if (cmd_i.acc_one) begin
      xn_q <= 64'sd1;
      xd_q <= 64'sd1;
    end
    if (cmd_i.k_neg)   k_q <= 64'd0 - k_q;
    if (cmd_i.k_shift) k_q <= k_q >> 1;
    if (cmd_i.finish) begin
      out_q.status <= cmd_i.fin_status;
      if (cmd_i.fin_status == ST_OK) begin
        out_q.res_num <= xn_q;
        out_q.res_den <= xd_q[62:0];
      end else begin
        out_q.res_num <= 64'sd0;
        out_q.res_den <= 63'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.mul_done  = mul_done;
    sts_o.mul_ovf   = mul_ovf;
    sts_o.norm_done = norm_done;
    sts_o.norm_st   = norm_st;
    sts_o.as_ovf    = cmd_i.sub ?
                      (tn_q[63] != td_q[63]) && (as_r[63] != tn_q[63]) :
                      (tn_q[63] == td_q[63]) && (as_r[63] != tn_q[63]);
    sts_o.yn_zero   = yn_q == 64'sd0;
    sts_o.yn_min    = yn_q == S64_MIN;
    sts_o.yn_neg    = yn_q[63];
    sts_o.xn_zero   = xn_q == 64'sd0;
    sts_o.k_zero    = k_q == 64'd0;
    sts_o.k_sign    = k_q[63];
    sts_o.k_min     = k_q == S64_MIN;
    sts_o.k_lsb     = k_q[0];
    sts_o.k_last    = k_q[63:1] == 63'd0;
    sts_o.tn_min    = tn_q == S64_MIN;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/cra_ctrl.sv
// Sequencer: walks each operation through multiplies, checks and
// normalisations, issuing commands to cra_dp. Uses cra_pkg.
module cra_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    in_func_i,
  input  cra_pkg::sts_t sts_i,
  output cra_pkg::cmd_t cmd_o
);
  import cra_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_AS_M1   = 5'd2;
  localparam logic [4:0] S_AS_M2   = 5'd3;
  localparam logic [4:0] S_AS_ADD  = 5'd4;
  localparam logic [4:0] S_AS_M3   = 5'd5;
  localparam logic [4:0] S_MU_M1   = 5'd6;
  localparam logic [4:0] S_MU_M2   = 5'd7;
  localparam logic [4:0] S_DV_M1   = 5'd8;
  localparam logic [4:0] S_DV_CHK  = 5'd9;
  localparam logic [4:0] S_DV_M2   = 5'd10;
  localparam logic [4:0] S_DV_NEG  = 5'd11;
  localparam logic [4:0] S_NORM    = 5'd12;
  localparam logic [4:0] S_PW_NINV = 5'd13;
  localparam logic [4:0] S_PW_INIT = 5'd14;
  localparam logic [4:0] S_PW_LOOP = 5'd15;
  localparam logic [4:0] S_PW_AM1  = 5'd16;
  localparam logic [4:0] S_PW_AM2  = 5'd17;
  localparam logic [4:0] S_PW_AN   = 5'd18;
  localparam logic [4:0] S_PW_SH   = 5'd19;
  localparam logic [4:0] S_PW_BM1  = 5'd20;
  localparam logic [4:0] S_PW_BM2  = 5'd21;
  localparam logic [4:0] S_PW_BN   = 5'd22;
  localparam logic [4:0] S_FIN     = 5'd23;

  logic [4:0] state_q, state_d, nxt;
  logic [2:0] func_q, func_d;
  logic [1:0] st_q, st_d;
  logic       issued_q, issued_d, mul_step, norm_step;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    func_d    = func_q;
    st_d      = st_q;
    issued_d  = issued_q;
    mul_step  = 1'b0;
    norm_step = 1'b0;
    nxt       = S_FIN;
    in_ready_o = state_q == S_IDLE;
    cmd_o.sub = func_q == FN_SUB;
    cmd_o.fin_status = st_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          func_d     = in_func_i;
          st_d       = ST_OK;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (func_q)
          FN_ADD, FN_SUB: state_d = S_AS_M1;
          FN_MUL:         state_d = S_MU_M1;
          FN_DIV: begin
            if (sts_i.yn_zero) begin
              st_d    = ST_DZ;
              state_d = S_FIN;
            end else begin
              state_d = S_DV_M1;
            end
          end
          FN_POW: begin
            if (sts_i.k_zero) begin
              cmd_o.acc_one = 1'b1;
              state_d       = S_FIN;
            end else if (sts_i.k_sign) begin
              if (sts_i.xn_zero) begin
                st_d    = ST_DZ;
                state_d = S_FIN;
              end else begin
                cmd_o.swap_t = 1'b1;
                state_d      = S_PW_NINV;
              end
            end else begin
              cmd_o.copy_xy = 1'b1;
              cmd_o.acc_one = 1'b1;
              state_d       = S_PW_LOOP;
            end
          end
          default: begin
            cmd_o.x_to_t = 1'b1;
            state_d      = S_NORM;
          end
        endcase
      end
      S_AS_M1: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_XN; cmd_o.mul_b = SEL_YD; nxt = S_AS_M2;
      end
      S_AS_M2: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_YN; cmd_o.mul_b = SEL_XD;
        cmd_o.mul_dst = 1'b1; nxt = S_AS_ADD;
      end
      S_AS_ADD: begin
        if (sts_i.as_ovf) begin
          st_d    = ST_OVF;
          state_d = S_FIN;
        end else begin
          cmd_o.addsub = 1'b1;
          state_d      = S_AS_M3;
        end
      end
      S_AS_M3: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_XD; cmd_o.mul_b = SEL_YD;
        cmd_o.mul_dst = 1'b1; nxt = S_NORM;
      end
      S_MU_M1: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_XN; cmd_o.mul_b = SEL_YN; nxt = S_MU_M2;
      end
      S_MU_M2: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_XD; cmd_o.mul_b = SEL_YD;
        cmd_o.mul_dst = 1'b1; nxt = S_NORM;
      end
      S_DV_M1: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_XN; cmd_o.mul_b = SEL_YD; nxt = S_DV_CHK;
      end
      S_DV_CHK: begin
        if (sts_i.yn_min) begin
          st_d    = ST_OVF;
          state_d = S_FIN;
        end else begin
          state_d = S_DV_M2;
        end
      end
      S_DV_M2: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_XD; cmd_o.mul_b = SEL_YN;
        cmd_o.mul_abs_b = 1'b1; cmd_o.mul_dst = 1'b1; nxt = S_DV_NEG;
      end
      S_DV_NEG: begin
        if (sts_i.yn_neg && sts_i.tn_min) begin
          st_d    = ST_OVF;
          state_d = S_FIN;
        end else begin
          cmd_o.neg_tn = sts_i.yn_neg;
          state_d      = S_NORM;
        end
      end
      S_NORM: begin
        norm_step = 1'b1; nxt = S_FIN;
      end
      S_PW_NINV: begin
        norm_step = 1'b1; cmd_o.norm_dst = 1'b1; nxt = S_PW_INIT;
      end
      S_PW_INIT: begin
        if (sts_i.k_min) begin
          st_d    = ST_OVF;
          state_d = S_FIN;
        end else begin
          cmd_o.k_neg   = 1'b1;
          cmd_o.acc_one = 1'b1;
          state_d       = S_PW_LOOP;
        end
      end
      S_PW_LOOP: state_d = sts_i.k_lsb ? S_PW_AM1 : S_PW_SH;
      S_PW_AM1: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_XN; cmd_o.mul_b = SEL_YN; nxt = S_PW_AM2;
      end
      S_PW_AM2: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_XD; cmd_o.mul_b = SEL_YD;
        cmd_o.mul_dst = 1'b1; nxt = S_PW_AN;
      end
      S_PW_AN: begin
        norm_step = 1'b1; nxt = S_PW_SH;
      end
      S_PW_SH: begin
        cmd_o.k_shift = 1'b1;
        state_d = sts_i.k_last ? S_FIN : S_PW_BM1;
      end
      S_PW_BM1: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_YN; cmd_o.mul_b = SEL_YN; nxt = S_PW_BM2;
      end
      S_PW_BM2: begin
        mul_step = 1'b1; cmd_o.mul_a = SEL_YD; cmd_o.mul_b = SEL_YD;
        cmd_o.mul_dst = 1'b1; nxt = S_PW_BN;
      end
      S_PW_BN: begin
        norm_step = 1'b1; cmd_o.norm_dst = 1'b1; nxt = S_PW_LOOP;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // start a unit once on entry, then wait for its done pulse
    if (mul_step) begin
      if (!issued_q) begin
        cmd_o.mul_start = 1'b1;
        issued_d        = 1'b1;
      end else if (sts_i.mul_done) begin
        issued_d = 1'b0;
        if (sts_i.mul_ovf) begin
          st_d    = ST_OVF;
          state_d = S_FIN;
        end else begin
          state_d = nxt;
        end
      end
    end
    if (norm_step) begin
      if (!issued_q) begin
        cmd_o.norm_start = 1'b1;
        issued_d         = 1'b1;
      end else if (sts_i.norm_done) begin
        issued_d = 1'b0;
        if (sts_i.norm_st != ST_OK) begin
          st_d    = sts_i.norm_st;
          state_d = S_FIN;
        end else begin
          state_d = nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      func_q   <= FN_NORM;
      st_q     <= ST_OK;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      func_q   <= func_d;
      st_q     <= st_d;
      issued_q <= issued_d;
    end
  end

endmodule

// File: rtl/cra_chk.sv
// Port-level checks for checked_rational_alu, bound to the top level.
// Uses cra_pkg.
module cra_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cra_pkg::out_t out_data_o
);
  import cra_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.res_num == 64'sd0 && out_data_o.res_den == 63'd1)
    else $error("failed transaction carries a value");

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OK |-> out_data_o.res_den != 63'd0)
    else $error("zero denominator on ok result");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !$rose(out_valid_o))
    else $error("accepted transaction not taken up");

endmodule

bind checked_rational_alu cra_chk u_cra_chk (.*);

// File: sim/checked_rational_alu_tb.sv
// Self-checking testbench for checked_rational_alu: directed and random
// rational operations, predicted in-bench and compared per field.
// Depends on rtl/cra_pkg.sv and rtl/checked_rational_alu.sv.
`timescale 1ns / 1ps

module checked_rational_alu_tb;
  import cra_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 2000;
  localparam longint S_MIN = 64'sh8000_0000_0000_0000;
  localparam longint S_MAX = 64'sh7fff_ffff_ffff_ffff;

  typedef struct {
    longint n;
    longint d;
  } frac_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  in_t   in_data_i   = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;

  in_t   pending_q[$];
  out_t  result_q[$];
  int    idle_pct  = 0;
  int    stall_pct = 0;
  int    n_errors  = 0;
  int    quiet_cycles = 0;

  checked_rational_alu dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------- arithmetic predictor ----------------
  function automatic bit [63:0] abs_u(longint x);
    return x < 0 ? 64'd0 - 64'(x) : 64'(x);
  endfunction

  function automatic logic [1:0] mul_chk(longint a, longint b, output longint o);
    bit [63:0] ua, ub, lim, p;
    bit neg;
    ua  = abs_u(a);
    ub  = abs_u(b);
    neg = (a < 0) != (b < 0);
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    o = 0;
    if (ua != 0 && ub > lim / ua) return ST_OVF;
    p = ua * ub;
    o = neg ? longint'(64'd0 - p) : longint'(p);
    return ST_OK;
  endfunction

  function automatic bit [63:0] gcd_of(bit [63:0] a, bit [63:0] b);
    bit [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a != 0 ? a : 64'd1;
  endfunction

  function automatic logic [1:0] reduce(output frac_t o, input longint num, input longint den);
    bit [63:0] g;
    o.n = 0;
    o.d = 1;
    if (den == 0) return ST_DZ;
    if (den < 0) begin
      if (num == S_MIN || den == S_MIN) return ST_OVF;
      num = -num;
      den = -den;
    end
    if (num == S_MIN) return ST_OVF;
    g = gcd_of(abs_u(num), 64'(den));
    o.n = num / longint'(g);
    o.d = den / longint'(g);
    return ST_OK;
  endfunction

  function automatic logic [1:0] frac_mul(frac_t a, frac_t b, output frac_t o);
    longint n, d;
    logic [1:0] e;
    o.n = 0;
    o.d = 1;
    e = mul_chk(a.n, b.n, n);
    if (e != ST_OK) return e;
    e = mul_chk(a.d, b.d, d);
    if (e != ST_OK) return e;
    return reduce(o, n, d);
  endfunction

  function automatic logic [1:0] frac_addsub(frac_t a, frac_t b, bit sub, output frac_t o);
    longint n1, n2, n, d;
    logic [1:0] e;
    o.n = 0;
    o.d = 1;
    e = mul_chk(a.n, b.d, n1);
    if (e != ST_OK) return e;
    e = mul_chk(b.n, a.d, n2);
    if (e != ST_OK) return e;
    if (sub) begin
      n = n1 - n2;
      if ((n1 < 0) != (n2 < 0) && (n < 0) != (n1 < 0)) return ST_OVF;
    end else begin
      n = n1 + n2;
      if ((n1 < 0) == (n2 < 0) && (n < 0) != (n1 < 0)) return ST_OVF;
    end
    e = mul_chk(a.d, b.d, d);
    if (e != ST_OK) return e;
    return reduce(o, n, d);
  endfunction

  function automatic logic [1:0] frac_div(frac_t a, frac_t b, output frac_t o);
    longint n, d;
    logic [1:0] e;
    o.n = 0;
    o.d = 1;
    if (b.n == 0) return ST_DZ;
    e = mul_chk(a.n, b.d, n);
    if (e != ST_OK) return e;
    if (b.n == S_MIN) return ST_OVF;
    e = mul_chk(a.d, b.n < 0 ? -b.n : b.n, d);
    if (e != ST_OK) return e;
    if (b.n < 0) begin
      if (n == S_MIN) return ST_OVF;
      n = -n;
    end
    return reduce(o, n, d);
  endfunction

  function automatic logic [1:0] frac_pow(frac_t a, longint ex, output frac_t o);
    frac_t base, acc, t;
    bit [63:0] k;
    logic [1:0] e;
    base = a;
    acc.n = 1;
    acc.d = 1;
    o = acc;
    if (ex == 0) return ST_OK;
    if (ex < 0) begin
      if (a.n == 0) return ST_DZ;
      e = reduce(base, a.d, a.n);
      if (e != ST_OK) return e;
      if (ex == S_MIN) return ST_OVF;
      ex = -ex;
    end
    k = 64'(ex);
    while (k > 0) begin
      if (k[0]) begin
        e = frac_mul(acc, base, t);
        if (e != ST_OK) return e;
        acc = t;
      end
      k = k >> 1;
      if (k == 0) break;
      e = frac_mul(base, base, t);
      if (e != ST_OK) return e;
      base = t;
    end
    o = acc;
    return ST_OK;
  endfunction

  function automatic out_t predict_result(in_t it);
    frac_t a, b, r;
    logic [1:0] st;
    out_t res;
    a.n = it.a_num;
    a.d = it.a_den;
    b.n = it.b_num;
    b.d = longint'({1'b0, it.b_den});
    case (it.func)
      FN_ADD:  st = frac_addsub(a, b, 1'b0, r);
      FN_SUB:  st = frac_addsub(a, b, 1'b1, r);
      FN_MUL:  st = frac_mul(a, b, r);
      FN_DIV:  st = frac_div(a, b, r);
      FN_POW:  st = frac_pow(a, it.exponent, r);
      default: st = reduce(r, a.n, a.d);
    endcase
    if (st != ST_OK) begin
      r.n = 0;
      r.d = 1;
    end
    res.res_num = r.n;
    res.res_den = r.d[62:0];
    res.status  = st;
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic longint pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return longint'($urandom_range(0, 40)) - 20;
      3: case ($urandom_range(0, 4))
           0: return S_MIN;
           1: return S_MAX;
           2: return S_MIN + 1;
           3: return -1;
           default: return 0;
         endcase
      4, 5: return longint'({$urandom, $urandom});
      6: return longint'($signed($urandom));
      7: return longint'($signed($urandom_range(0, 2000000))) - 1000000;
      default: return (longint'($urandom_range(1, 9)) << $urandom_range(0, 60))
                      * ($urandom_range(0, 1) ? 1 : -1);
    endcase
  endfunction

  function automatic in_t random_item();
    in_t it;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12)      it.func = FN_NORM;
    else if (sel < 30) it.func = FN_ADD;
    else if (sel < 48) it.func = FN_SUB;
    else if (sel < 64) it.func = FN_MUL;
    else if (sel < 80) it.func = FN_DIV;
    else if (sel < 96) it.func = FN_POW;
    else               it.func = 3'($urandom_range(6, 7));
    it.a_num = pick_value();
    it.a_den = $urandom_range(0, 3) == 0 ? pick_value()
             : longint'($urandom_range(1, 30));
    if ($urandom_range(0, 9) == 0) it.a_den = 0;
    it.b_num = pick_value();
    case ($urandom_range(0, 9))
      0: it.b_den = 63'({$urandom, $urandom});
      1: it.b_den = $urandom_range(0, 1) ? '1 : '0;
      2: it.b_den = 63'($urandom);
      default: it.b_den = 63'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 19))
      0: it.exponent = longint'({$urandom, $urandom});
      1: it.exponent = $urandom_range(0, 1) ? S_MIN : S_MAX;
      2: it.exponent = longint'($urandom_range(0, 127)) - 63;
      default: it.exponent = longint'($urandom_range(0, 24)) - 12;
    endcase
    return it;
  endfunction

  function automatic in_t make_item(logic [2:0] f, longint an, longint ad, longint bn,
                                    longint bd, longint ex);
    in_t it;
    it.func     = f;
    it.a_num    = an;
    it.a_den    = ad;
    it.b_num    = bn;
    it.b_den    = bd[62:0];
    it.exponent = ex;
    return it;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i) begin
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        result_q.push_back(predict_result(in_data_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data_i <= pending_q.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid_i <= nxt_valid;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          n_errors++;
          $display("%t: unexpected result num=%0d den=%0d status=%0d", $time,
                   out_data_o.res_num, out_data_o.res_den, out_data_o.status);
        end else begin
          exp_r = result_q.pop_front();
          if (out_data_o.status !== exp_r.status) begin
            n_errors++;
            $display("%t: status expected %0d actual %0d", $time, exp_r.status,
                     out_data_o.status);
          end
          if (out_data_o.res_num !== exp_r.res_num) begin
            n_errors++;
            $display("%t: res_num expected %0d actual %0d", $time, exp_r.res_num,
                     out_data_o.res_num);
          end
          if (out_data_o.res_den !== exp_r.res_den) begin
            n_errors++;
            $display("%t: res_den expected %0d actual %0d", $time, exp_r.res_den,
                     out_data_o.res_den);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("checked_rational_alu verification failed");
        $finish;
      end
    end
  end

  task automatic run_phase(int idle, int stall, int n_items);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n_items) pending_q.push_back(random_item());
    while (pending_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed corners
    pending_q.push_back(make_item(FN_NORM, 6, -4, 0, 1, 0));
    pending_q.push_back(make_item(FN_NORM, S_MIN, -1, 0, 1, 0));
    pending_q.push_back(make_item(FN_NORM, 3, S_MIN, 0, 1, 0));
    pending_q.push_back(make_item(FN_NORM, 1, 0, 0, 1, 0));
    pending_q.push_back(make_item(FN_NORM, S_MIN, 1, 0, 1, 0));
    pending_q.push_back(make_item(FN_NORM, 0, -7, 0, 1, 0));
    pending_q.push_back(make_item(FN_ADD, S_MAX, 1, 1, 1, 0));
    pending_q.push_back(make_item(FN_ADD, 1, 2, 1, 3, 0));
    pending_q.push_back(make_item(FN_SUB, S_MIN + 1, 1, 2, 1, 0));
    pending_q.push_back(make_item(FN_SUB, 5, -6, -1, 3, 0));
    pending_q.push_back(make_item(FN_ADD, 1, 1, 1, 0, 0));
    pending_q.push_back(make_item(FN_MUL, S_MAX, S_MAX, S_MAX, S_MAX, 0));
    pending_q.push_back(make_item(FN_MUL, -4, 9, 3, 8, 0));
    pending_q.push_back(make_item(FN_DIV, 1, 2, 0, 5, 0));
    pending_q.push_back(make_item(FN_DIV, 1, 2, S_MIN, 5, 0));
    pending_q.push_back(make_item(FN_DIV, 3, 4, -9, 2, 0));
    pending_q.push_back(make_item(FN_DIV, S_MIN, 1, -1, 1, 0));
    pending_q.push_back(make_item(FN_POW, 7, 3, 0, 1, 0));
    pending_q.push_back(make_item(FN_POW, 0, 3, 0, 1, -2));
    pending_q.push_back(make_item(FN_POW, 2, 3, 0, 1, S_MIN));
    pending_q.push_back(make_item(FN_POW, 2, 3, 0, 1, 5));
    pending_q.push_back(make_item(FN_POW, -3, 2, 0, 1, -3));
    pending_q.push_back(make_item(FN_POW, -1, 1, 0, 1, S_MAX));
    pending_q.push_back(make_item(3'd6, 10, -15, 0, 1, 0));
    pending_q.push_back(make_item(3'd7, -8, 12, 0, 1, 0));
    run_phase(0, 0, 400);
    run_phase(49, 0, 400);
    run_phase(0, 49, 400);
    run_phase(31, 31, 400);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && result_q.size() == 0) begin
      $display("checked_rational_alu verification clean");
    end else begin
      $display("checked_rational_alu verification failed");
    end
    $finish;
  end

endmodule
